// ===== design/lbsr_pkg.sv =====
// ----------------------------------------------------------------------------
// LED bar segment renderer package
// Shared types and constants for the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package lbsr_pkg;

  // Action codes of a render request.
  localparam logic [2:0] ACT_NONE   = 3'd0;
  localparam logic [2:0] ACT_BOTTOM = 3'd1;
  localparam logic [2:0] ACT_TOP    = 3'd2;
  localparam logic [2:0] ACT_MIDDLE = 3'd3;
  localparam logic [2:0] ACT_STATIC = 3'd4;
  localparam logic [2:0] ACT_RANDOM = 3'd5;

  // Option bits.
  localparam int OPT_INVERT   = 0;
  localparam int OPT_MODULATE = 1;
  localparam int OPT_NO_OFF   = 2;

  localparam logic [9:0] LEVEL_MAX  = 10'd1023;
  localparam int         TABLE_DEPTH = 64;
  localparam int         THR_W      = 10;

  // One prepared job handed from the front end to the back end.
  typedef struct packed {
    logic        is_table;
    logic [9:0]  first_led;
    logic [6:0]  led_count;
    logic [2:0]  action;
    logic [3:0]  spacing;
    logic        write_off;
    logic [23:0] fore_color;
    logic [23:0] back_color;
    logic [6:0]  nfill;
    logic [9:0]  level;
    logic [5:0]  table_index;
    logic [9:0]  table_value;
  } job_t;

endpackage

// ===== design/led_bar_segment_renderer.sv =====
// ----------------------------------------------------------------------------
// LED bar segment renderer
// Turns a segment request into one pixel result per LED, in fill order.
// ----------------------------------------------------------------------------
// A render request passes the front end, the queue and the back end; with
//   colour modulation the front end first runs 3 channels through a divider.
// The back end gives one result per cycle while it walks a segment and takes
//   a new request from the queue only once the walk is done; the queue lets
//   the front end prepare the next request meanwhile.
// Reset clears all control state; the threshold table is not cleared.
module led_bar_segment_renderer #(
  parameter int MAX_SEGMENT_LEDS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [9:0]  in_first_led,
  input  logic [6:0]  in_led_count,
  input  logic [2:0]  in_action,
  input  logic [3:0]  in_spacing,
  input  logic [2:0]  in_options,
  input  logic [23:0] in_fore_color,
  input  logic [23:0] in_back_color,
  input  logic [9:0]  in_level,
  input  logic [5:0]  in_table_index,
  input  logic [9:0]  in_table_value,
  output logic        out_valid,
  output logic [10:0] out_pixel_index,
  output logic [23:0] out_pixel_color,
  output logic        out_write_enable,
  output logic        out_last
);

  lbsr_pkg::job_t push_job, head_job;
  logic           push, pop, q_empty, q_full;

  // Request front end.
  lbsr_front #(
    .MAX_SEGMENT_LEDS (MAX_SEGMENT_LEDS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_cmd         (in_cmd),
    .in_first_led   (in_first_led),
    .in_led_count   (in_led_count),
    .in_action      (in_action),
    .in_spacing     (in_spacing),
    .in_options     (in_options),
    .in_fore_color  (in_fore_color),
    .in_back_color  (in_back_color),
    .in_level       (in_level),
    .in_table_index (in_table_index),
    .in_table_value (in_table_value),
    .q_full         (q_full),
    .q_push         (push),
    .q_job          (push_job)
  );

  // Job queue.
  lbsr_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  // Pixel back end.
  lbsr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_job            (head_job),
    .q_pop            (pop),
    .out_valid        (out_valid),
    .out_pixel_index  (out_pixel_index),
    .out_pixel_color  (out_pixel_color),
    .out_write_enable (out_write_enable),
    .out_last         (out_last)
  );

endmodule

// ===== design/lbsr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lbsr_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Storage and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/lbsr_queue.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Two-entry FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
module lbsr_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  lbsr_pkg::job_t push_job,
  input  logic           pop,
  output lbsr_pkg::job_t head_job,
  output logic           empty,
  output logic           full
);

  lbsr_pkg::job_t mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  assign head_job = mem_r[rd_ptr_r];
  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);

endmodule

// ===== design/lbsr_front.sv =====
// ----------------------------------------------------------------------------
// Front end
// Accepts requests, scales the level to a lit count, optionally blends the
// colour with an iterative divider and pushes each valid job into the queue.
// ----------------------------------------------------------------------------
module lbsr_front #(
  parameter int MAX_SEGMENT_LEDS = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  input  logic           in_cmd,
  input  logic [9:0]     in_first_led,
  input  logic [6:0]     in_led_count,
  input  logic [2:0]     in_action,
  input  logic [3:0]     in_spacing,
  input  logic [2:0]     in_options,
  input  logic [23:0]    in_fore_color,
  input  logic [23:0]    in_back_color,
  input  logic [9:0]     in_level,
  input  logic [5:0]     in_table_index,
  input  logic [9:0]     in_table_value,
  input  logic           q_full,
  output logic           q_push,
  output lbsr_pkg::job_t q_job
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_DSET = 3'd2;
  localparam logic [2:0] ST_DRUN = 3'd3;
  localparam logic [2:0] ST_DFIN = 3'd4;
  localparam logic [2:0] ST_PUSH = 3'd5;

  logic [2:0]     state_r, state_nxt;
  lbsr_pkg::job_t job_r, job_nxt;
  logic           modulate_r, modulate_nxt;
  logic [1:0]     ch_r, ch_nxt;
  logic [3:0]     it_r, it_nxt;
  logic [13:0]    dvd_r, dvd_nxt;
  logic [6:0]     rem_r, rem_nxt;
  logic           neg_r, neg_nxt;

  logic           accept;
  logic [6:0]     cnt_sat;
  logic [9:0]     lvl_eff;
  logic           act_ok;
  logic [16:0]    scaled;
  logic [6:0]     lit;
  logic [7:0]     f_ch, b_ch;
  logic [8:0]     diff;
  logic [7:0]     mag;
  logic [14:0]    prod;
  logic [7:0]     rem_sh;
  logic           ge;
  logic [7:0]     blend;

  assign accept = start && !busy;
  assign busy   = (state_r != ST_IDLE) || q_full;

  always_comb begin
    // Request classification.
    cnt_sat = (in_led_count > 7'(MAX_SEGMENT_LEDS)) ? 7'(MAX_SEGMENT_LEDS) : in_led_count;
    lvl_eff = in_options[lbsr_pkg::OPT_INVERT] ? (lbsr_pkg::LEVEL_MAX - in_level) : in_level;
    act_ok  = (in_action == lbsr_pkg::ACT_BOTTOM) || (in_action == lbsr_pkg::ACT_TOP) ||
              (in_action == lbsr_pkg::ACT_MIDDLE) || (in_action == lbsr_pkg::ACT_STATIC) ||
              (in_action == lbsr_pkg::ACT_RANDOM);

    // Level scaling to the lit count.
    scaled = job_r.level * ({10'd0, job_r.led_count} + 17'd1);
    lit    = (scaled[16:10] > job_r.led_count) ? job_r.led_count : scaled[16:10];

    // Colour blend datapath for the current channel.
    f_ch   = job_r.fore_color[ch_r*8 +: 8];
    b_ch   = job_r.back_color[ch_r*8 +: 8];
    diff   = {1'b0, f_ch} - {1'b0, b_ch};
    mag    = diff[8] ? 8'(-diff) : diff[7:0];
    prod   = mag * job_r.nfill;
    rem_sh = {rem_r, dvd_r[13]};
    ge     = rem_sh >= {1'b0, job_r.led_count};
    blend  = neg_r ? (b_ch - dvd_r[7:0]) : (b_ch + dvd_r[7:0]);

    state_nxt    = state_r;
    job_nxt      = job_r;
    modulate_nxt = modulate_r;
    ch_nxt       = ch_r;
    it_nxt       = it_r;
    dvd_nxt      = dvd_r;
    rem_nxt      = rem_r;
    neg_nxt      = neg_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          job_nxt.is_table    = in_cmd;
          job_nxt.first_led   = in_first_led;
          job_nxt.led_count   = cnt_sat;
          job_nxt.action      = in_action;
          job_nxt.spacing     = in_spacing;
          job_nxt.write_off   = !in_options[lbsr_pkg::OPT_NO_OFF];
          job_nxt.fore_color  = in_fore_color;
          job_nxt.back_color  = in_back_color;
          job_nxt.nfill       = 7'd0;
          job_nxt.level       = lvl_eff;
          job_nxt.table_index = in_table_index;
          job_nxt.table_value = in_table_value;
          modulate_nxt        = in_options[lbsr_pkg::OPT_MODULATE];
          if (in_cmd) begin
            state_nxt = ST_PUSH;
          end else if (cnt_sat != 7'd0 && act_ok) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        // nfill holds the lit count during the blend.
        job_nxt.nfill = lit;
        ch_nxt        = 2'd0;
        state_nxt     = modulate_r ? ST_DSET : ST_PUSH;
        if (!modulate_r) begin
          if (job_r.action == lbsr_pkg::ACT_STATIC || job_r.action == lbsr_pkg::ACT_RANDOM) begin
            job_nxt.nfill = job_r.led_count;
          end
        end
      end
      ST_DSET: begin
        dvd_nxt   = prod[13:0];
        neg_nxt   = diff[8];
        rem_nxt   = 7'd0;
        it_nxt    = 4'd0;
        state_nxt = ST_DRUN;
      end
      ST_DRUN: begin
        // One restoring division step per cycle.
        rem_nxt = ge ? 7'(rem_sh - {1'b0, job_r.led_count}) : rem_sh[6:0];
        dvd_nxt = {dvd_r[12:0], ge};
        it_nxt  = it_r + 4'd1;
        if (it_r == 4'd13) begin
          state_nxt = ST_DFIN;
        end
      end
      ST_DFIN: begin
        job_nxt.fore_color[ch_r*8 +: 8] = blend;
        ch_nxt = ch_r + 2'd1;
        if (ch_r == 2'd2) begin
          state_nxt = ST_PUSH;
          if (job_r.action == lbsr_pkg::ACT_STATIC || job_r.action == lbsr_pkg::ACT_RANDOM) begin
            job_nxt.nfill = job_r.led_count;
          end
        end else begin
          state_nxt = ST_DSET;
        end
      end
      ST_PUSH: begin
        if (!q_full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    modulate_r <= modulate_nxt;
    ch_r       <= ch_nxt;
    it_r       <= it_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
  end

  assign q_push = (state_r == ST_PUSH) && !q_full;
  assign q_job  = job_r;

endmodule

// ===== design/lbsr_back.sv =====
// ----------------------------------------------------------------------------
// Back end
// Pops jobs, writes threshold entries and walks a segment one LED per cycle.
// ----------------------------------------------------------------------------
module lbsr_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_empty,
  input  lbsr_pkg::job_t q_job,
  output logic           q_pop,
  output logic           out_valid,
  output logic [10:0]    out_pixel_index,
  output logic [23:0]    out_pixel_color,
  output logic           out_write_enable,
  output logic           out_last
);

  lbsr_pkg::job_t job_r, job_nxt;
  logic           run_r, run_nxt;
  logic [6:0]     k_r, k_nxt;
  logic [10:0]    pos_r, pos_nxt;
  logic [7:0]     step_r, step_nxt;
  logic [3:0]     space_r, space_nxt;

  logic           valid_r;
  logic [10:0]    idx_r;
  logic [23:0]    color_r;
  logic           we_r;
  logic           last_r;

  logic [23:0]    color;
  logic           lit_slot;
  logic           we;
  logic           last;
  logic [7:0]     step_mid;
  logic [9:0]     thr;
  logic           tbl_we;
  logic [5:0]     raddr;

  assign q_pop  = !run_r && !q_empty;
  assign tbl_we = q_pop && q_job.is_table;
  assign raddr  = k_nxt[5:0];

  lbsr_ram #(
    .WIDTH (lbsr_pkg::THR_W),
    .DEPTH (lbsr_pkg::TABLE_DEPTH)
  ) u_thr (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (q_job.table_index),
    .wdata (q_job.table_value),
    .raddr (raddr),
    .rdata (thr)
  );

  always_comb begin
    // Per-LED result.
    color    = (job_r.nfill > k_r) ? job_r.fore_color : job_r.back_color;
    lit_slot = (space_r == 4'd0);
    we       = lit_slot && ((color != 24'd0) || job_r.write_off);
    if (job_r.action == lbsr_pkg::ACT_RANDOM && thr > job_r.level) begin
      we = 1'b0;
    end
    last     = (k_r + 7'd1 == job_r.led_count);
    step_mid = $signed(step_r) <= 0 ? step_r - 8'd1 : step_r + 8'd1;

    job_nxt   = job_r;
    run_nxt   = run_r;
    k_nxt     = k_r;
    pos_nxt   = pos_r;
    step_nxt  = step_r;
    space_nxt = space_r;

    if (run_r) begin
      // Walk to the next LED in fill order.
      k_nxt = k_r + 7'd1;
      if (job_r.action == lbsr_pkg::ACT_MIDDLE) begin
        step_nxt = 8'(-step_mid);
        if ($signed(step_r) <= 0) begin
          space_nxt = lit_slot ? job_r.spacing : space_r - 4'd1;
        end
      end else begin
        space_nxt = lit_slot ? job_r.spacing : space_r - 4'd1;
      end
      pos_nxt = pos_r + {{3{step_nxt[7]}}, step_nxt};
      if (last) begin
        run_nxt = 1'b0;
        k_nxt   = 7'd0;
      end
    end else if (q_pop && !q_job.is_table) begin
      // Load a segment job.
      job_nxt   = q_job;
      run_nxt   = 1'b1;
      k_nxt     = 7'd0;
      space_nxt = 4'd0;
      case (q_job.action)
        lbsr_pkg::ACT_TOP: begin
          pos_nxt  = {1'b0, q_job.first_led} + {4'd0, q_job.led_count} - 11'd1;
          step_nxt = 8'hFF;
        end
        lbsr_pkg::ACT_MIDDLE: begin
          pos_nxt  = {1'b0, q_job.first_led} + {5'd0, 6'((q_job.led_count - 7'd1) >> 1)};
          step_nxt = 8'd0;
        end
        default: begin
          pos_nxt  = {1'b0, q_job.first_led};
          step_nxt = 8'd1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r   <= 1'b0;
      k_r     <= 7'd0;
      valid_r <= 1'b0;
    end else begin
      run_r   <= run_nxt;
      k_r     <= k_nxt;
      valid_r <= run_r;
    end
  end

  // Walk state and output register.
  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    pos_r   <= pos_nxt;
    step_r  <= step_nxt;
    space_r <= space_nxt;
    idx_r   <= pos_r;
    color_r <= color;
    we_r    <= we;
    last_r  <= last;
  end

  assign out_valid        = valid_r;
  assign out_pixel_index  = idx_r;
  assign out_pixel_color  = color_r;
  assign out_write_enable = we_r;
  assign out_last         = last_r;

  // The LED counter stays inside the segment.
  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> (k_r < job_r.led_count)) else $error("LED counter beyond segment");

  // A job is only taken while no segment is being walked.
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !run_r) else $error("pop during segment walk");

  // The final LED of a segment ends the walk.
  a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && last_r) |-> !run_r) else $error("walk continues after last LED");

endmodule
